// ===== src/tfn_pkg.sv =====
// shared types and constants of the triangle face normal unit
// no dependencies; every other file but tfn_stream_if imports this package
package tfn_pkg;

  localparam int POS_W   = 16;
  localparam int IDX_W   = 16;
  localparam int EDGE_W  = POS_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int R_W     = 15;
  localparam int SQ_W    = 2 * R_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int Q_W     = 15;
  localparam int ACC_W   = 64;
  localparam int VAL_W   = ACC_W + 2;
  localparam int NUM_W   = SQ_W + 30;
  localparam int SHIFT_W = 5;
  localparam int NORM_W  = 16;

  localparam int LAT_CROSS = 3;
  localparam int LAT_SCALE = 6;
  localparam int LAT_RDIV  = 2 * Q_W;

  typedef struct packed {
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic signed [POS_W-1:0] a_x;
    logic signed [POS_W-1:0] a_y;
    logic signed [POS_W-1:0] a_z;
    logic signed [POS_W-1:0] b_x;
    logic signed [POS_W-1:0] b_y;
    logic signed [POS_W-1:0] b_z;
    logic signed [POS_W-1:0] c_x;
    logic signed [POS_W-1:0] c_y;
    logic signed [POS_W-1:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index_a;
    logic [IDX_W-1:0]         out_index_b;
    logic [IDX_W-1:0]         out_index_c;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } out_word_t;

  typedef struct packed {
    logic       deg;
    logic [2:0] neg;
  } flags_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } idx_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc_a;
    logic [ACC_W-1:0] acc_b;
    logic [Q_W-1:0]   q;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] sum;
  } rdiv_t;

endpackage

// ===== src/tfn_stream_if.sv =====
// valid/ready stream channel carrying one word of type T
// depends on nothing; payload types come from tfn_pkg
interface tfn_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tfn_cross.sv =====
// edge vectors and cross product, three register stages
// depends on tfn_pkg
module tfn_cross (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  tfn_pkg::in_word_t                   word_i,
  output logic signed [tfn_pkg::CROSS_W-1:0] n_o [3]
);
  import tfn_pkg::*;

  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  p_q  [6];
  logic signed [CROSS_W-1:0] n_q  [3];

  // e1 = a - c, e2 = b - a
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e1_q[0] <= EDGE_W'(word_i.a_x) - EDGE_W'(word_i.c_x);
      e1_q[1] <= EDGE_W'(word_i.a_y) - EDGE_W'(word_i.c_y);
      e1_q[2] <= EDGE_W'(word_i.a_z) - EDGE_W'(word_i.c_z);
      e2_q[0] <= EDGE_W'(word_i.b_x) - EDGE_W'(word_i.a_x);
      e2_q[1] <= EDGE_W'(word_i.b_y) - EDGE_W'(word_i.a_y);
      e2_q[2] <= EDGE_W'(word_i.b_z) - EDGE_W'(word_i.a_z);
      p_q[0]  <= e1_q[1] * e2_q[2];
      p_q[1]  <= e1_q[2] * e2_q[1];
      p_q[2]  <= e1_q[2] * e2_q[0];
      p_q[3]  <= e1_q[0] * e2_q[2];
      p_q[4]  <= e1_q[0] * e2_q[1];
      p_q[5]  <= e1_q[1] * e2_q[0];
      n_q[0]  <= CROSS_W'(p_q[0]) - CROSS_W'(p_q[1]);
      n_q[1]  <= CROSS_W'(p_q[2]) - CROSS_W'(p_q[3]);
      n_q[2]  <= CROSS_W'(p_q[4]) - CROSS_W'(p_q[5]);
    end
  end

  assign n_o = n_q;

endmodule

// ===== src/tfn_scale.sv =====
// magnitudes, block shift to 15 bits, squares and their sum
// depends on tfn_pkg; six register stages
module tfn_scale (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic signed [tfn_pkg::CROSS_W-1:0] n_i [3],
  output logic [tfn_pkg::SQ_W-1:0]           r2_o [3],
  output logic [tfn_pkg::SUM_W-1:0]          sum_o,
  output tfn_pkg::flags_t                    flags_o
);
  import tfn_pkg::*;

  logic [MAG_W-1:0]   mag4_q [3];
  logic [MAG_W-1:0]   mag5_q [3];
  logic [MAG_W-1:0]   mag6_q [3];
  logic [MAG_W-1:0]   max5_q;
  logic [SHIFT_W-1:0] shift6_q;
  logic [R_W-1:0]     r7_q   [3];
  logic [SQ_W-1:0]    r2_8_q [3];
  logic [SQ_W-1:0]    r2_9_q [3];
  logic [SUM_W-1:0]   sum9_q;
  flags_t             flags_q [LAT_SCALE];
  flags_t             flags_d;
  logic [MAG_W-1:0]   max_d;
  logic [SHIFT_W-1:0] shift_d;

  always_comb begin
    flags_d.deg = (n_i[0] == '0) && (n_i[1] == '0) && (n_i[2] == '0);
    for (int i = 0; i < 3; i++) flags_d.neg[i] = n_i[i][CROSS_W-1];
  end

  always_comb begin
    max_d = mag4_q[0];
    if (mag4_q[1] > max_d) max_d = mag4_q[1];
    if (mag4_q[2] > max_d) max_d = mag4_q[2];
  end

  // smallest shift that brings the largest magnitude below 2^15
  always_comb begin
    shift_d = '0;
    for (int b = R_W; b < MAG_W; b++) begin
      if (max5_q[b]) shift_d = SHIFT_W'(b - R_W + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= n_i[i][CROSS_W-1] ? MAG_W'(-n_i[i]) : MAG_W'(n_i[i]);
        mag5_q[i] <= mag4_q[i];
        mag6_q[i] <= mag5_q[i];
        r7_q[i]   <= R_W'(mag6_q[i] >> shift6_q);
        r2_8_q[i] <= r7_q[i] * r7_q[i];
        r2_9_q[i] <= r2_8_q[i];
      end
      max5_q   <= max_d;
      shift6_q <= shift_d;
      sum9_q   <= SUM_W'(r2_8_q[0]) + SUM_W'(r2_8_q[1]) + SUM_W'(r2_8_q[2]);
      flags_q[0] <= flags_d;
      for (int k = 1; k < LAT_SCALE; k++) flags_q[k] <= flags_q[k-1];
    end
  end

  assign r2_o    = r2_9_q;
  assign sum_o   = sum9_q;
  assign flags_o = flags_q[LAT_SCALE-1];

endmodule

// ===== src/tfn_rdiv_lane.sv =====
// rounded r * 2^14 / sqrt(sum), one quotient bit per two stages
// depends on tfn_pkg; keeps q^2*sum and q*sum so each trial needs only shifts and adds
module tfn_rdiv_lane (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [tfn_pkg::SQ_W-1:0]      r2_i,
  input  logic [tfn_pkg::SUM_W-1:0]     sum_i,
  output logic [tfn_pkg::Q_W-1:0]       q_o
);
  import tfn_pkg::*;

  rdiv_t            st0;
  rdiv_t            st_q  [1:Q_W];
  rdiv_t            mid_q [Q_W];
  logic [ACC_W-1:0] at_q  [Q_W];
  logic [ACC_W-1:0] bt_q  [Q_W];

  always_comb begin
    st0.acc_a = '0;
    st0.acc_b = '0;
    st0.q     = '0;
    st0.num   = NUM_W'(r2_i) << 30;
    st0.sum   = sum_i;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    rdiv_t            cur;
    logic [ACC_W-1:0] at_d;
    logic [ACC_W-1:0] bt_d;
    logic [VAL_W-1:0] val;
    logic             fits;

    if (k == 0) begin : g_first
      assign cur = st0;
    end else begin : g_next
      assign cur = st_q[k];
    end

    // candidate t = q + 2^B
    assign bt_d = cur.acc_b + (ACC_W'(cur.sum) << B);
    assign at_d = cur.acc_a + (cur.acc_b << (B + 1))
                + (ACC_W'(cur.sum) << (2 * B));
    // (2t-1)^2 * sum = 4 t^2 sum - 4 t sum + sum
    assign val  = (VAL_W'(at_q[k]) << 2) - (VAL_W'(bt_q[k]) << 2)
                + VAL_W'(mid_q[k].sum);
    assign fits = val <= VAL_W'(mid_q[k].num);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        mid_q[k] <= cur;
        at_q[k]  <= at_d;
        bt_q[k]  <= bt_d;
        st_q[k+1].num <= mid_q[k].num;
        st_q[k+1].sum <= mid_q[k].sum;
        if (fits) begin
          st_q[k+1].acc_a <= at_q[k];
          st_q[k+1].acc_b <= bt_q[k];
          st_q[k+1].q     <= mid_q[k].q | (Q_W'(1) << B);
        end else begin
          st_q[k+1].acc_a <= mid_q[k].acc_a;
          st_q[k+1].acc_b <= mid_q[k].acc_b;
          st_q[k+1].q     <= mid_q[k].q;
        end
      end
    end
  end

  assign q_o = st_q[Q_W].q;

endmodule

// ===== src/triangle_face_normal_unit.sv =====
// Triangle face normal unit: takes one triangle per cycle while the output is not stalled
// (three indices, three Q8.8 corners) and returns its unit normal in Q1.14, rounded to
// nearest, with the indices. Fully pipelined: a new word may enter every cycle unless a
// finished word waits; the longest part is the rounded normalisation, which resolves one
// quotient bit per two stages. The whole pipeline holds while a finished word waits, so
// in_i.ready drops only while out_o.valid is high and out_o.ready is low. Degenerate
// triangles give a zero normal with the degenerate flag set.
module triangle_face_normal_unit #(
  parameter int INDEX_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tfn_stream_if.sink   in_i,
  tfn_stream_if.source out_o
);
  import tfn_pkg::*;

  localparam int PIPE = LAT_CROSS + LAT_SCALE + LAT_RDIV;
  localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}}
                                        : IDX_W'((33'd1 << INDEX_BITS) - 33'd1);

  in_word_t                  word;
  logic                      adv;
  logic                      valid_q [PIPE];
  idx_t                      idx_q   [PIPE];
  flags_t                    flags_q [LAT_RDIV];
  logic signed [CROSS_W-1:0] n       [3];
  logic [SQ_W-1:0]           r2      [3];
  logic [SUM_W-1:0]          sum;
  flags_t                    flags;
  logic [Q_W-1:0]            q       [3];
  logic                      out_valid_q;
  out_word_t                 out_q;
  out_word_t                 out_d;
  logic signed [NORM_W-1:0]  norm_d  [3];

  assign word        = in_i.data;
  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  tfn_cross u_cross (.clk_i(clk_i), .adv_i(adv), .word_i(word), .n_o(n));

  tfn_scale u_scale (
    .clk_i(clk_i), .adv_i(adv), .n_i(n), .r2_o(r2), .sum_o(sum), .flags_o(flags)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tfn_rdiv_lane u_lane (
      .clk_i(clk_i), .adv_i(adv), .r2_i(r2[i]), .sum_i(sum), .q_o(q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE; k++) valid_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_i.valid;
      for (int k = 1; k < PIPE; k++) valid_q[k] <= valid_q[k-1];
      out_valid_q <= valid_q[PIPE-1];
    end
  end

  // indices and flags ride alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q[0].a <= word.index_a & IDX_MASK;
      idx_q[0].b <= word.index_b & IDX_MASK;
      idx_q[0].c <= word.index_c & IDX_MASK;
      for (int k = 1; k < PIPE; k++) idx_q[k] <= idx_q[k-1];
      flags_q[0] <= flags;
      for (int k = 1; k < LAT_RDIV; k++) flags_q[k] <= flags_q[k-1];
      out_q <= out_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flags_q[LAT_RDIV-1].deg) norm_d[i] = '0;
      else if (flags_q[LAT_RDIV-1].neg[i]) norm_d[i] = -NORM_W'(q[i]);
      else norm_d[i] = NORM_W'(q[i]);
    end
    out_d.out_index_a = idx_q[PIPE-1].a;
    out_d.out_index_b = idx_q[PIPE-1].b;
    out_d.out_index_c = idx_q[PIPE-1].c;
    out_d.normal_x    = norm_d[0];
    out_d.normal_y    = norm_d[1];
    out_d.normal_z    = norm_d[2];
    out_d.degenerate  = flags_q[LAT_RDIV-1].deg;
  end

endmodule

// ===== src/tfn_checker.sv =====
// port-level checks for the triangle face normal unit, bound to the top level
// depends on tfn_pkg
module tfn_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input tfn_pkg::out_word_t   out_data_i
);
  import tfn_pkg::*;

  localparam logic signed [NORM_W-1:0] ONE = NORM_W'(16384);

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.degenerate |->
      out_data_i.normal_x == '0 && out_data_i.normal_y == '0 && out_data_i.normal_z == '0)
    else $error("degenerate word with non-zero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      out_data_i.normal_x <= ONE && out_data_i.normal_x >= -ONE &&
      out_data_i.normal_y <= ONE && out_data_i.normal_y >= -ONE &&
      out_data_i.normal_z <= ONE && out_data_i.normal_z >= -ONE)
    else $error("normal component out of range");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled output word changed");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);

// ===== tb/tb_triangle_face_normal_unit.sv =====
// testbench for the triangle face normal unit: directed table then random triangles
// depends on tfn_pkg, tfn_stream_if and triangle_face_normal_unit
`timescale 1ns / 1ps

module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  localparam int LATENCY = LAT_CROSS + LAT_SCALE + LAT_RDIV + 1;
  localparam int N_RANDOM = 1030;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tfn_stream_if #(.T(in_word_t))  in_ch ();
  tfn_stream_if #(.T(out_word_t)) out_ch ();

  triangle_face_normal_unit #(.INDEX_BITS(IDX_W)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  out_word_t normal_q[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_degenerate = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  // rounded quotient bit by bit: largest q with q == 0 or (2q-1)^2 * s2 <= mag^2 << 30
  function automatic logic [14:0] round_quot(logic [63:0] mag, logic [63:0] s2);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] d;
    num = (mag * mag) << 30;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      t = q | (64'd1 << b);
      d = 64'd2 * t - 64'd1;
      if (d * d * s2 <= num) q = t;
    end
    return q[14:0];
  endfunction

  function automatic out_word_t face_normal(in_word_t w);
    out_word_t   r;
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] n [3];
    logic [63:0] mag [3];
    logic [63:0] m;
    logic [63:0] s2;
    logic [15:0] q;
    int sh;
    e1[0] = 64'(w.a_x) - 64'(w.c_x);
    e1[1] = 64'(w.a_y) - 64'(w.c_y);
    e1[2] = 64'(w.a_z) - 64'(w.c_z);
    e2[0] = 64'(w.b_x) - 64'(w.a_x);
    e2[1] = 64'(w.b_y) - 64'(w.a_y);
    e2[2] = 64'(w.b_z) - 64'(w.a_z);
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r = '0;
    r.out_index_a = w.index_a;
    r.out_index_b = w.index_b;
    r.out_index_c = w.index_c;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    m = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      if (mag[i] > m) m = mag[i];
    end
    sh = 0;
    while ((m >> sh) >= 64'd32768) sh++;
    s2 = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> sh;
      s2 += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = {1'b0, round_quot(mag[i], s2)};
      if (n[i] < 0) q = -q;
      case (i)
        0: r.normal_x = q;
        1: r.normal_y = q;
        default: r.normal_z = q;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch %0d: %s", n_checked, msg);
    n_errors++;
  endtask

  // result side: random stall and check against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t exp_w;
    out_word_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (normal_q.size() == 0) begin
          report_mismatch("unexpected word from the unit");
        end else begin
          exp_w = normal_q.pop_front();
          if (got.out_index_a !== exp_w.out_index_a)
            report_mismatch($sformatf("index_a got %0h expected %0h",
                                      got.out_index_a, exp_w.out_index_a));
          if (got.out_index_b !== exp_w.out_index_b)
            report_mismatch($sformatf("index_b got %0h expected %0h",
                                      got.out_index_b, exp_w.out_index_b));
          if (got.out_index_c !== exp_w.out_index_c)
            report_mismatch($sformatf("index_c got %0h expected %0h",
                                      got.out_index_c, exp_w.out_index_c));
          if (got.normal_x !== exp_w.normal_x)
            report_mismatch($sformatf("normal_x got %0h expected %0h",
                                      got.normal_x, exp_w.normal_x));
          if (got.normal_y !== exp_w.normal_y)
            report_mismatch($sformatf("normal_y got %0h expected %0h",
                                      got.normal_y, exp_w.normal_y));
          if (got.normal_z !== exp_w.normal_z)
            report_mismatch($sformatf("normal_z got %0h expected %0h",
                                      got.normal_z, exp_w.normal_z));
          if (got.degenerate !== exp_w.degenerate)
            report_mismatch($sformatf("degenerate got %0h expected %0h",
                                      got.degenerate, exp_w.degenerate));
          if (exp_w.degenerate) n_degenerate++;
          n_checked++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic in_word_t make_tri(logic [15:0] ia, logic [15:0] ib, logic [15:0] ic,
                                        logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                                        logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    in_word_t w;
    w = {ia, ib, ic, ax, ay, az, bx, by, bz, cx, cy, cz};
    return w;
  endfunction

  function automatic logic [15:0] rand_pos(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 1023)) - 16'd512;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_word_t rand_tri();
    in_word_t w;
    int mode;
    int shape;
    mode = $urandom_range(0, 9);
    mode = mode < 3 ? 0 : (mode == 3 ? 1 : 2);
    w = {16'($urandom()), 16'($urandom()), 16'($urandom()),
         rand_pos(mode), rand_pos(mode), rand_pos(mode),
         rand_pos(mode), rand_pos(mode), rand_pos(mode),
         rand_pos(mode), rand_pos(mode), rand_pos(mode)};
    shape = $urandom_range(0, 19);
    // some coincident corners and collinear triangles
    if (shape == 0) begin
      w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
    end else if (shape == 1) begin
      w.c_x = 16'(2 * w.b_x - w.a_x);
      w.c_y = 16'(2 * w.b_y - w.a_y);
      w.c_z = 16'(2 * w.b_z - w.a_z);
    end
    return w;
  endfunction

  // valid stays high after an accept so words can follow back to back
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    normal_q.push_back(face_normal(w));
  endtask

  in_word_t  tri_table [$];
  out_word_t known [$];
  logic      has_known [$];

  initial begin
    out_word_t z;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    z = '0;
    // table: triangle, whether the answer is typed in, and the answer
    tri_table.push_back(make_tri(0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    z.out_index_b = 1; z.out_index_c = 2; z.degenerate = 1'b1;
    known.push_back(z); has_known.push_back(1'b1);
    // unit right triangle in xy plane: normal +z
    tri_table.push_back(make_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 16'h0100, 0, 0,
                                 0, 16'h0100, 0));
    z = '0; z.out_index_a = 16'hffff; z.out_index_b = 16'hffff; z.out_index_c = 16'hffff;
    z.normal_z = 16'sd16384;
    known.push_back(z); has_known.push_back(1'b1);
    tri_table.push_back(make_tri(3, 4, 5, 0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0));
    z = '0; z.out_index_a = 3; z.out_index_b = 4; z.out_index_c = 5;
    z.normal_z = -16'sd16384;
    known.push_back(z); has_known.push_back(1'b1);
    // collinear corners
    tri_table.push_back(make_tri(7, 8, 9, 16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                                 16'h0200, 0, 0, 0));
    z = '0; z.out_index_a = 7; z.out_index_b = 8; z.out_index_c = 9; z.degenerate = 1'b1;
    known.push_back(z); has_known.push_back(1'b1);
    // extremes of the positions
    tri_table.push_back(make_tri(16'h8000, 16'h7fff, 16'haaaa, 16'h8000, 16'h8000,
                                 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                                 16'h7fff, 16'h8000));
    tri_table.push_back(make_tri(16'h5555, 0, 1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                                 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    tri_table.push_back(make_tri(1, 2, 3, 16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000,
                                 16'h7fff, 16'h0000, 16'h0000, 16'h8000));
    tri_table.push_back(make_tri(10, 11, 12, 16'hffff, 0, 0, 0, 16'h0001, 0, 0, 0,
                                 16'h0001));
    tri_table.push_back(make_tri(13, 14, 15, 0, 0, 0, 16'h0001, 16'h0001, 0, 16'hffff,
                                 16'h0001, 16'h0001));
    tri_table.push_back(make_tri(16, 17, 18, 16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0,
                                 16'h7fff));
    for (int i = 4; i < tri_table.size(); i++) begin
      known.push_back('0); has_known.push_back(1'b0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tri_table[i]) begin
      send_word(tri_table[i]);
      if (has_known[i] && normal_q[$] !== known[i])
        report_mismatch($sformatf("predictor disagrees with table row %0d", i));
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) send_word(rand_tri());
      // hold off until the pipeline has drained
      if (ph == 1) begin
        in_ch.valid <= 1'b0;
        while (normal_q.size() != 0) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("checked %0d triangles, %0d degenerate, over four idling phases",
             n_checked, n_degenerate);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
